>>> hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // register byte addresses
    localparam logic [2:0] ADDR_LARGER_FIRST = 3'd0;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } entry_t;

    // per-cell control: at most one bit set
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

    // compare of the incoming key against the key a cell holds
    typedef struct packed {
        logic worse;
        logic same;
    } cell_flags_t;

    // one result beat, last field in the lowest bits
    typedef struct packed {
        logic [1:0]       pad;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] head_value;
        logic [KEY_W-1:0] head_key;
        logic             head_valid;
        logic [VAL_W-1:0] taken_value;
        logic [KEY_W-1:0] taken_key;
    } result_data_t;

    typedef struct packed {
        status_t      status;
        result_data_t data;
    } result_t;

endpackage

>>> hdl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

// Sorted priority queue of up to 16 key/value entries, built as a row of cells
// with the best entry in cell 0. Each s_ beat is an insert (s_tuser = 0) or an
// extract (s_tuser = 1) and yields exactly one m_ beat carrying the status, the
// extracted entry (zero unless an extract succeeded), the head after the
// operation and the entry count. Every cell compares the incoming key with its
// own in parallel and either holds, loads the new entry, takes its left
// neighbor (insert) or takes its right neighbor (extract). The block sustains
// one beat per cycle while s_tready is high, and a result appears on m_ the
// cycle after its beat is accepted unless an earlier result still waits
// there. A two-slot output buffer lets a second beat enter while a result
// still waits; s_tready drops only when both slots are occupied.
// An insert ranks behind every strictly better key and ahead of equal keys,
// but never ahead of an equal head.
// Insert into a full queue returns status 1, extract from an empty queue
// status 2; the queue is left untouched in both cases. Register larger_first
// (address 0x0, bit 0) selects largest key first; write it only while idle.
module sorted_priority_queue_unit (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // item_key[31:0], item_value[63:32]
    input  logic [0:0]    s_tuser,   // op[0]

    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // taken_key[31:0], taken_value[63:32],
                                     // head_valid[64], head_key[96:65],
                                     // head_value[128:97], count[133:129], zero pad
    output logic [1:0]    m_tuser,   // status[1:0]

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int N = spq_pkg::CAPACITY;

    logic                       larger_first_reg;
    logic [spq_pkg::CNT_W-1:0]  count_reg;
    logic [spq_pkg::CNT_W-1:0]  count_next;

    spq_pkg::entry_t      new_entry;
    spq_pkg::entry_t      cell_entry [N];
    spq_pkg::entry_t      left_in    [N];
    spq_pkg::entry_t      right_in   [N];
    spq_pkg::cell_flags_t cell_flags [N];
    spq_pkg::cell_ctrl_t  cell_ctrl  [N];

    logic [N-1:0] go;      // new key belongs at or before this cell
    logic [N-1:0] ge;      // this cell shifts or loads on insert

    logic             accept;
    logic             is_extract;
    logic             full;
    logic             empty;
    logic             ins_ok;
    logic             ext_ok;
    spq_pkg::result_t result;
    logic             buf_out_valid;
    spq_pkg::result_t buf_out;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            larger_first_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr == spq_pkg::ADDR_LARGER_FIRST) begin
            larger_first_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == spq_pkg::ADDR_LARGER_FIRST) begin
            prdata[0] = larger_first_reg;
        end
    end

    // ---------------------------------------------------------------- decode
    assign new_entry.key   = s_tdata[31:0];
    assign new_entry.value = s_tdata[63:32];
    assign is_extract      = (spq_pkg::op_t'(s_tuser[0]) == spq_pkg::OP_EXTRACT);
    assign accept          = s_tvalid && s_tready;
    assign full            = (count_reg == spq_pkg::CNT_W'(N));
    assign empty           = (count_reg == '0);
    assign ins_ok          = !is_extract && !full;
    assign ext_ok          = is_extract && !empty;

    // ---------------------------------------------------------------- cell row
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            // neighbors: cell 0 has no left, the last cell no right
            if (gi == 0) begin : g_left_edge
                assign left_in[gi] = new_entry;
                // head: take only a strictly better key, or fill an empty row
                assign go[gi] = empty || (!cell_flags[gi].worse && !cell_flags[gi].same);
                assign ge[gi] = go[gi];

                always_comb begin
                    cell_ctrl[gi].take_right = accept && ext_ok;
                    cell_ctrl[gi].load_new   = accept && ins_ok && ge[gi];
                    cell_ctrl[gi].take_left  = 1'b0;
                end
            end else begin : g_left
                assign left_in[gi] = cell_entry[gi-1];
                // behind the head: stop at the first key that is not better,
                // or at the first empty cell
                assign go[gi] = (spq_pkg::CNT_W'(gi) >= count_reg) || !cell_flags[gi].worse;
                assign ge[gi] = go[gi] || go[0];

                always_comb begin
                    cell_ctrl[gi].take_right = accept && ext_ok;
                    cell_ctrl[gi].load_new   = accept && ins_ok && ge[gi] && !ge[gi-1];
                    cell_ctrl[gi].take_left  = accept && ins_ok && ge[gi] && ge[gi-1];
                end
            end

            if (gi == N - 1) begin : g_right_edge
                assign right_in[gi] = cell_entry[gi];
            end else begin : g_right
                assign right_in[gi] = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .aclk         (aclk),
                .ctrl         (cell_ctrl[gi]),
                .larger_first (larger_first_reg),
                .new_entry    (new_entry),
                .left_entry   (left_in[gi]),
                .right_entry  (right_in[gi]),
                .entry        (cell_entry[gi]),
                .flags        (cell_flags[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- count
    always_comb begin
        count_next = count_reg;
        if (accept && ins_ok) begin
            count_next = count_reg + spq_pkg::CNT_W'(1);
        end else if (accept && ext_ok) begin
            count_next = count_reg - spq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb begin
        spq_pkg::entry_t head;
        result = '0;

        if (ins_ok) begin
            head = go[0] ? new_entry : cell_entry[0];
        end else if (ext_ok) begin
            head = cell_entry[1];
        end else begin
            head = cell_entry[0];
        end

        if (is_extract) begin
            result.status = empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_DONE;
        end else begin
            result.status = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_DONE;
        end

        if (ext_ok) begin
            result.data.taken_key   = cell_entry[0].key;
            result.data.taken_value = cell_entry[0].value;
        end

        // hide the head when the queue ends up empty
        if (count_next != '0) begin
            result.data.head_valid = 1'b1;
            result.data.head_key   = head.key;
            result.data.head_value = head.value;
        end
        result.data.count = count_next;
    end

    // hold finished results; a second slot absorbs one more beat
    spq_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (buf_out_valid),
        .out_ready (m_tready),
        .out_data  (buf_out)
    );

    assign m_tvalid = buf_out_valid;
    assign m_tdata  = buf_out.data;
    assign m_tuser  = buf_out.status;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= spq_pkg::CNT_W'(N))
        else $error("entry count above capacity");

    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_extract && full) |=> (count_reg == spq_pkg::CNT_W'(N)))
        else $error("insert into full queue changed the count");

    a_empty_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_extract && empty) |=> (count_reg == '0))
        else $error("extract from empty queue changed the count");

    a_stall_means_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

>>> hdl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic                 aclk,
    input  spq_pkg::cell_ctrl_t  ctrl,
    input  logic                 larger_first,
    input  spq_pkg::entry_t      new_entry,
    input  spq_pkg::entry_t      left_entry,
    input  spq_pkg::entry_t      right_entry,
    output spq_pkg::entry_t      entry,
    output spq_pkg::cell_flags_t flags
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // rank the incoming key against the held one
    always_comb begin
        flags.same  = (new_entry.key == entry_reg.key);
        flags.worse = larger_first ? (new_entry.key < entry_reg.key)
                                   : (new_entry.key > entry_reg.key);
    end

    always_comb begin
        priority if (ctrl.load_new) begin
            entry_next = new_entry;
        end else if (ctrl.take_left) begin
            entry_next = left_entry;
        end else if (ctrl.take_right) begin
            entry_next = right_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hdl/spq_skid.sv
`timescale 1ns / 1ps

module spq_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  spq_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output spq_pkg::result_t out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    spq_pkg::result_t out_reg;
    spq_pkg::result_t skid_reg;

    logic push;
    logic take;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign take      = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !take) begin
                skid_reg <= in_data;
            end else begin
                out_reg <= in_data;
            end
        end
    end

endmodule

>>> test/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic [0:0]   s_tuser,

    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [1:0]   m_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic [31:0]  prdata,
    input  logic         pready,

    output int           fail_count,
    output int           results_owed,
    output int           results_seen,
    output int           refusals_seen
);

    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [VAL_W-1:0] shadow_vals [CAPACITY];
    int               shadow_count;
    logic             larger_first;

    result_t          owed_results [$];
    result_t          got;
    result_t          want;

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // true when key a ranks strictly behind key b under the current order
    function automatic bit ranks_behind(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return larger_first ? (a < b) : (a > b);
    endfunction

    // apply one beat to the shadow queue and return the result it owes
    function automatic result_t apply_queue_op(input op_t op, input logic [KEY_W-1:0] k,
                                               input logic [VAL_W-1:0] v);
        result_t r;
        int      pos;
        int      i;
        r = '0;
        r.status = STATUS_DONE;
        if (op == OP_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = STATUS_FULL;
            end else begin
                // never go ahead of an equal head
                if (shadow_count == 0 || (!ranks_behind(k, shadow_keys[0]) && k != shadow_keys[0])) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < shadow_count && ranks_behind(k, shadow_keys[pos]))
                        pos++;
                end
                for (i = shadow_count; i > pos; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_vals[i] = shadow_vals[i-1];
                end
                shadow_keys[pos] = k;
                shadow_vals[pos] = v;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.data.taken_key   = shadow_keys[0];
                r.data.taken_value = shadow_vals[0];
                for (i = 1; i < shadow_count; i++) begin
                    shadow_keys[i-1] = shadow_keys[i];
                    shadow_vals[i-1] = shadow_vals[i];
                end
                shadow_count--;
            end
        end
        if (shadow_count > 0) begin
            r.data.head_valid = 1'b1;
            r.data.head_key   = shadow_keys[0];
            r.data.head_value = shadow_vals[0];
        end
        r.data.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = 0;
            larger_first = 1'b0;
            owed_results.delete();
        end else begin
            // results first: a result never belongs to a beat taken at the same edge
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.data   = result_data_t'(m_tdata);
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed, status %0d",
                                              m_tuser));
                end else begin
                    want = owed_results.pop_front();
                    results_seen++;
                    if (want.status != STATUS_DONE)
                        refusals_seen++;
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.data.taken_key !== want.data.taken_key)
                        report_mismatch($sformatf("taken_key %h, want %h",
                                                  got.data.taken_key, want.data.taken_key));
                    if (got.data.taken_value !== want.data.taken_value)
                        report_mismatch($sformatf("taken_value %h, want %h",
                                                  got.data.taken_value, want.data.taken_value));
                    if (got.data.head_valid !== want.data.head_valid)
                        report_mismatch($sformatf("head_valid %b, want %b",
                                                  got.data.head_valid, want.data.head_valid));
                    if (got.data.head_key !== want.data.head_key)
                        report_mismatch($sformatf("head_key %h, want %h",
                                                  got.data.head_key, want.data.head_key));
                    if (got.data.head_value !== want.data.head_value)
                        report_mismatch($sformatf("head_value %h, want %h",
                                                  got.data.head_value, want.data.head_value));
                    if (got.data.count !== want.data.count)
                        report_mismatch($sformatf("count %0d, want %0d",
                                                  got.data.count, want.data.count));
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_queue_op(op_t'(s_tuser), s_tdata[31:0],
                                                      s_tdata[63:32]));
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_LARGER_FIRST)
                        larger_first = pwdata[0];
                end else if (paddr == ADDR_LARGER_FIRST && prdata[0] !== larger_first) begin
                    report_mismatch($sformatf("larger_first reads %b, want %b",
                                              prdata[0], larger_first));
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

>>> test/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;

    import spq_pkg::*;

    // no register lives here: writes must be dropped
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    logic         aclk = 1'b0;
    logic         aresetn;

    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;    // item_key[31:0], item_value[63:32]
    logic [0:0]   s_tuser;    // op[0]

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;    // taken_key, taken_value, head_valid, head_key,
                              // head_value, count, zero pad
    logic [1:0]   m_tuser;    // status[1:0]

    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int           fail_count;
    int           results_owed;
    int           results_seen;
    int           refusals_seen;
    int           beats_sent;
    int           stall_left;
    bit           quiet;      // when set, neither side idles

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_priority_queue_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    spq_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .results_owed  (results_owed),
        .results_seen  (results_seen),
        .refusals_seen (refusals_seen)
    );

    // idle length: mostly none, often short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // keys cluster on a small pool so equal keys and equal heads come up often
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 5);
        if (r == 4)
            return 32'h0;
        if (r == 5)
            return 32'hFFFF_FFFF;
        if (r == 6)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return $urandom;
    endfunction

    // receiver: random stalls, changed at the falling edge
    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // drive one beat after an optional gap, hold until it is taken
    task automatic send_beat(input op_t op, input logic [31:0] k, input logic [31:0] v);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {v, k};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // lower valid and hold until every owed result has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // pull everything out so a new order starts from an empty queue
    task automatic empty_queue();
        repeat (CAPACITY + 1) send_beat(OP_EXTRACT, $urandom, $urandom);
        wait_drained();
    endtask

    // bursts of random ops; the insert share per burst sweeps the queue
    // between empty and full
    task automatic random_phase(input int n);
        int done;
        int burst;
        int bias;
        op_t op;
        done = 0;
        while (done < n) begin
            case ($urandom_range(0, 3))
                0: bias = 15;
                1: bias = 50;
                2: bias = 85;
                default: bias = 97;
            endcase
            quiet = ($urandom_range(0, 5) == 0);
            burst = $urandom_range(8, 48);
            repeat (burst) begin
                op = ($urandom_range(0, 99) < bias) ? OP_INSERT : OP_EXTRACT;
                send_beat(op, pick_key(), $urandom);
                done++;
            end
            // now and then hold the sender until the queue has answered everything
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        int i;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_INSERT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        stall_left = 0;
        beats_sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // smallest first
        apb_access(1'b1, ADDR_LARGER_FIRST, 32'h0);
        apb_access(1'b0, ADDR_LARGER_FIRST, 32'h0);

        // directed: empty refusal, extreme keys, equal head, fill, full refusal
        send_beat(OP_EXTRACT, 32'hDEAD_BEEF, 32'h1234_5678);
        send_beat(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_beat(OP_INSERT, 32'h0, 32'h1);            // equal head: lands behind it
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'h2);    // goes ahead of the equal tail
        for (i = 5; i < 16; i++)
            send_beat(OP_INSERT, i, i);
        send_beat(OP_INSERT, 32'h7, 32'hAAAA_5555);    // now full
        send_beat(OP_INSERT, 32'h3, 32'h5555_AAAA);    // refused full
        send_beat(OP_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_EXTRACT, 32'h0, 32'h0);
        send_beat(OP_INSERT, 32'h0, 32'h3);            // new best head
        send_beat(OP_EXTRACT, 32'h0, 32'h0);
        wait_drained();

        random_phase(420);
        empty_queue();

        // largest first; upper data bits and the spare address must be ignored
        apb_access(1'b1, ADDR_LARGER_FIRST, 32'hFFFF_FFFF);
        apb_access(1'b1, ADDR_SPARE, 32'h0);
        apb_access(1'b0, ADDR_LARGER_FIRST, 32'h0);
        send_beat(OP_INSERT, 32'h0, 32'h10);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'h11);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'h12);   // equal head under this order
        send_beat(OP_EXTRACT, 32'h0, 32'h0);
        random_phase(420);
        empty_queue();

        apb_access(1'b1, ADDR_LARGER_FIRST, 32'hFFFF_FFFE);
        apb_access(1'b0, ADDR_LARGER_FIRST, 32'h0);
        random_phase(400);
        empty_queue();

        apb_access(1'b1, ADDR_LARGER_FIRST, $urandom | 32'h1);
        apb_access(1'b0, ADDR_LARGER_FIRST, 32'h0);
        random_phase(400);

        wait_drained();
        $display("Sent %0d beats across both key orders; %0d results checked, %0d refused.",
                 beats_sent, results_seen, refusals_seen);
        if (fail_count == 0) begin
            $display("** sorted_priority_queue_unit: PASSED **");
        end else begin
            $display("** sorted_priority_queue_unit: FAILED **");
        end
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Run did not finish in time.");
        $display("** sorted_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule

>>> files.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/spq_skid.sv
hdl/sorted_priority_queue_unit.sv
test/spq_checker.sv
test/tb_sorted_priority_queue_unit.sv
